>>> hdl/scc_pkg.sv
// Shared constants, types and state encoding for the span collision centroid block.
package scc_pkg;

  localparam int SLOTS      = 16;
  localparam int COORD_BITS = 11;
  localparam int RUN_LIMIT  = 16;
  localparam int EMIT_SLOTS = (SLOTS < RUN_LIMIT) ? SLOTS : RUN_LIMIT;
  localparam int SLOT_AW    = $clog2(SLOTS);
  localparam int SLOT_W     = 4;
  localparam int OPCODE_W   = 2;
  localparam int POLY_W     = 16;
  localparam int COUNT_W    = 26;
  localparam int SUM_W      = 38;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int QUOT_W     = COORD_BITS;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FRAME_START = 2'd0,
    OP_SPAN        = 2'd1,
    OP_FRAME_END   = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_MOD_A,
    ST_RD_B,
    ST_MOD_B,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_DIV,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   x_sum;
    logic [SUM_W-1:0]   y_sum;
    logic [POLY_W-1:0]  partner;
  } slot_entry_t;

endpackage

>>> hdl/scc_if.sv
// Valid/ready channel interfaces for span items and centroid results.
interface scc_in_if;
  logic                              valid;
  logic                              ready;
  logic [scc_pkg::OPCODE_W-1:0]      opcode;
  logic [scc_pkg::SLOT_W-1:0]        first_slot;
  logic [scc_pkg::SLOT_W-1:0]        second_slot;
  logic [scc_pkg::COORD_BITS-1:0]    row;
  logic [scc_pkg::COORD_BITS-1:0]    span_begin;
  logic [scc_pkg::COORD_BITS-1:0]    span_finish;
  logic [scc_pkg::POLY_W-1:0]        first_polygon;
  logic [scc_pkg::POLY_W-1:0]        second_polygon;

  modport source (
    output valid, opcode, first_slot, second_slot, row, span_begin, span_finish,
           first_polygon, second_polygon,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_slot, second_slot, row, span_begin, span_finish,
           first_polygon, second_polygon,
    output ready
  );
endinterface

interface scc_out_if;
  logic                              valid;
  logic                              ready;
  logic [scc_pkg::SLOT_W-1:0]        slot_index;
  logic [scc_pkg::COUNT_W-1:0]       pixel_count;
  logic [scc_pkg::COORD_BITS-1:0]    mean_x;
  logic [scc_pkg::COORD_BITS-1:0]    mean_y;
  logic [scc_pkg::POLY_W-1:0]        partner_polygon;
  logic                              last_slot;

  modport source (
    output valid, slot_index, pixel_count, mean_x, mean_y, partner_polygon, last_slot,
    input  ready
  );
  modport sink (
    input  valid, slot_index, pixel_count, mean_x, mean_y, partner_polygon, last_slot,
    output ready
  );
endinterface

>>> hdl/span_collision_centroid_core.sv
// Top level: collision slot table in one memory, span accumulate and frame-end centroid run.
// Span item: accept, then read-modify-write of each slot in turn on the slot memory.
// Frame start clears the per-slot valid bits. Opcode 3 and reversed spans are accepted and dropped.
// Frame end: per slot read, load, QUOT_W divider steps, done, output; EMIT_SLOTS
// results; a result waits in the output register while the next slot is computed.
// Reset clears the FSM, valid bits and output valid; no clearing pass over the memory.
module span_collision_centroid_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  scc_in_if.sink     item_i,
  scc_out_if.source  result_o
);
  import scc_pkg::*;

  state_e state_q, state_d;

  // latched item fields
  logic [SLOT_W-1:0]     s1_q, s2_q;
  logic [COORD_BITS-1:0] row_q, xb_q, xe_q;
  logic [POLY_W-1:0]     p1_q, p2_q;

  logic [COORD_BITS-1:0] len;
  logic [PROD_W-1:0]     p_bl_q, p_dy_q;
  logic [PROD_W:0]       p_tri_q;

  // slot memory
  slot_entry_t           mem [SLOTS];
  slot_entry_t           rd_data_q;
  logic                  rd_valid_q;
  logic [SLOTS-1:0]      valid_q;
  logic [SLOT_AW-1:0]    rd_addr, wr_addr;
  slot_entry_t           wr_data, entry;
  logic                  mem_we;

  logic [SLOT_W-1:0]     cur_slot;
  logic [POLY_W-1:0]     cur_partner;
  logic                  slot_ok;
  logic [COUNT_W:0]      sum_cnt;
  logic                  fits;

  logic                  in_ready, in_xfer;
  logic                  span_ok;
  logic [SLOT_AW-1:0]    emit_idx_q;
  logic                  emit_last;

  logic                  div_start;
  logic [QUOT_W-1:0]     quo_x, quo_y;
  logic                  div_x_done, div_y_done;

  logic                  out_load;
  logic                  out_valid_q;
  logic [SLOT_W-1:0]     out_idx_q;
  logic [COUNT_W-1:0]    out_cnt_q;
  logic [COORD_BITS-1:0] out_mx_q, out_my_q;
  logic [POLY_W-1:0]     out_partner_q;
  logic                  out_last_q;

  assign in_xfer   = item_i.valid && in_ready;
  assign span_ok   = (item_i.span_finish >= item_i.span_begin);
  assign emit_last = (emit_idx_q == SLOT_AW'(EMIT_SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (op_e'(item_i.opcode))
            OP_SPAN:      state_d = span_ok ? ST_RD_A : ST_IDLE;
            OP_FRAME_END: state_d = ST_EM_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_A:   state_d = ST_MOD_A;
      ST_MOD_A:  state_d = ST_RD_B;
      ST_RD_B:   state_d = ST_MOD_B;
      ST_MOD_B:  state_d = ST_IDLE;
      ST_EM_RD:  state_d = ST_EM_LD;
      ST_EM_LD:  state_d = ST_EM_DIV;
      ST_EM_DIV: state_d = div_x_done ? ST_EM_OUT : ST_EM_DIV;
      ST_EM_OUT: begin
        if (out_load) begin
          state_d = emit_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    rd_addr   = emit_idx_q;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_RD_A:   rd_addr = SLOT_AW'(s1_q);
      ST_MOD_A:  mem_we = slot_ok;
      ST_RD_B:   rd_addr = SLOT_AW'(s2_q);
      ST_MOD_B:  mem_we = slot_ok;
      ST_EM_LD:  div_start = 1'b1;
      ST_EM_OUT: out_load = !out_valid_q || result_o.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q  <= item_i.first_slot;
      s2_q  <= item_i.second_slot;
      row_q <= item_i.row;
      xb_q  <= item_i.span_begin;
      xe_q  <= item_i.span_finish;
      p1_q  <= item_i.first_polygon;
      p2_q  <= item_i.second_polygon;
    end
  end

  // products settle during the first read cycle and are stable for both updates
  assign len = xe_q - xb_q;

  always_ff @(posedge clk_i) begin
    p_bl_q  <= PROD_W'(xb_q) * PROD_W'(len);
    p_tri_q <= (PROD_W + 1)'(len) * (PROD_W + 1)'({1'b0, len} + 1'b1);
    p_dy_q  <= PROD_W'(row_q) * PROD_W'(len);
  end

  // read-modify-write of the current slot
  assign cur_slot    = (state_q == ST_MOD_A) ? s1_q : s2_q;
  assign cur_partner = (state_q == ST_MOD_A) ? p2_q : p1_q;
  assign slot_ok     = (32'(cur_slot) < 32'(SLOTS));
  assign wr_addr     = SLOT_AW'(cur_slot);
  assign entry       = rd_valid_q ? rd_data_q : '0;
  assign sum_cnt     = {1'b0, entry.count} + (COUNT_W + 1)'(len);
  assign fits        = !sum_cnt[COUNT_W];

  always_comb begin
    wr_data         = entry;
    wr_data.partner = cur_partner;
    if (fits) begin
      wr_data.count = sum_cnt[COUNT_W-1:0];
      wr_data.x_sum = entry.x_sum + SUM_W'(p_bl_q) + SUM_W'(p_tri_q >> 1);
      wr_data.y_sum = entry.y_sum + SUM_W'(p_dy_q);
    end
  end

  // second update reads after the first write has landed, so a repeated slot sees it
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q  <= mem[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (in_xfer && (op_e'(item_i.opcode) == OP_FRAME_START)) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // emit sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_idx_q <= '0;
    end else if (in_xfer) begin
      emit_idx_q <= '0;
    end else if (out_load) begin
      emit_idx_q <= emit_idx_q + 1'b1;
    end
  end

  scc_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (entry.x_sum),
    .divisor_i  (entry.count),
    .quotient_o (quo_x),
    .done_o     (div_x_done)
  );

  scc_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (entry.y_sum),
    .divisor_i  (entry.count),
    .quotient_o (quo_y),
    .done_o     (div_y_done)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q     <= SLOT_W'(emit_idx_q);
      out_cnt_q     <= entry.count;
      out_mx_q      <= (entry.count == '0) ? '0 : quo_x;
      out_my_q      <= (entry.count == '0) ? '0 : quo_y;
      out_partner_q <= entry.partner;
      out_last_q    <= emit_last;
    end
  end

  assign item_i.ready             = in_ready;
  assign result_o.valid           = out_valid_q;
  assign result_o.slot_index      = out_idx_q;
  assign result_o.pixel_count     = out_cnt_q;
  assign result_o.mean_x          = out_mx_q;
  assign result_o.mean_y          = out_my_q;
  assign result_o.partner_polygon = out_partner_q;
  assign result_o.last_slot       = out_last_q;

  // both dividers run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EM_DIV) && div_x_done |-> div_y_done)
    else $error("divider lanes out of step");

  // a new result only appears from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EM_OUT))
    else $error("result loaded outside output state");

  // empty slot reports zero means
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_cnt_q == '0) |-> (out_mx_q == '0) && (out_my_q == '0))
    else $error("nonzero mean for empty slot");

  // table writes only happen in the span update cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_MOD_A) || (state_q == ST_MOD_B))
    else $error("slot memory written outside span update");

endmodule

>>> hdl/scc_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QUOT_W bits.
module scc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [scc_pkg::SUM_W-1:0]     dividend_i,
  input  logic [scc_pkg::COUNT_W-1:0]   divisor_i,
  output logic [scc_pkg::QUOT_W-1:0]    quotient_o,
  output logic                          done_o
);
  import scc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dsh_q, dsh_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = SUM_W'(divisor_i) << (QUOT_W - 1);
      quo_d = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QUOT_W-2:0], ge};
      dsh_d = dsh_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(QUOT_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> dv/scc_centroid_checker.sv
// Checker: tracks the collision slot table from accepted span items and checks centroid results.
module scc_centroid_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  scc_in_if           item_i,
  scc_out_if          result_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    count;
    logic [COORD_BITS-1:0] mx;
    logic [COORD_BITS-1:0] my;
    logic [POLY_W-1:0]     partner;
    logic                  last;
  } centroid_t;

  logic [COUNT_W-1:0] count_tbl   [SLOTS];
  logic [SUM_W-1:0]   xsum_tbl    [SLOTS];
  logic [SUM_W-1:0]   ysum_tbl    [SLOTS];
  logic [POLY_W-1:0]  partner_tbl [SLOTS];

  centroid_t   expected_centroids[$];
  int unsigned mismatches;

  function void wipe_slots();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      count_tbl[i]   = '0;
      xsum_tbl[i]    = '0;
      ysum_tbl[i]    = '0;
      partner_tbl[i] = '0;
    end
  endfunction

  function void accumulate_overlap(logic [SLOT_W-1:0] idx, logic [COORD_BITS-1:0] len,
                                   logic [SUM_W-1:0] dx, logic [SUM_W-1:0] dy,
                                   logic [POLY_W-1:0] partner);
    logic [COUNT_W:0] grown;
    if (idx >= SLOTS) return;
    grown = {1'b0, count_tbl[idx]} + (COUNT_W+1)'(len);
    // a span that would wrap the count leaves the sums alone, partner still updates
    if (!grown[COUNT_W]) begin
      count_tbl[idx] = grown[COUNT_W-1:0];
      xsum_tbl[idx]  = xsum_tbl[idx] + dx;
      ysum_tbl[idx]  = ysum_tbl[idx] + dy;
    end
    partner_tbl[idx] = partner;
  endfunction

  function void queue_centroids();
    centroid_t c;
    for (int unsigned i = 0; i < EMIT_SLOTS; i++) begin
      c.slot    = SLOT_W'(i);
      c.count   = count_tbl[i];
      c.mx      = (count_tbl[i] == '0) ? '0
                : COORD_BITS'(xsum_tbl[i] / SUM_W'(count_tbl[i]));
      c.my      = (count_tbl[i] == '0) ? '0
                : COORD_BITS'(ysum_tbl[i] / SUM_W'(count_tbl[i]));
      c.partner = partner_tbl[i];
      c.last    = (i + 1 == EMIT_SLOTS);
      expected_centroids.push_back(c);
    end
  endfunction

  function void apply_item();
    logic [COORD_BITS-1:0] len;
    logic [SUM_W-1:0]      dx;
    logic [SUM_W-1:0]      dy;
    case (item_i.opcode)
      OP_FRAME_START: wipe_slots();
      OP_SPAN: begin
        // reversed spans are dropped whole; empty spans still record partners
        if (item_i.span_finish >= item_i.span_begin) begin
          len = item_i.span_finish - item_i.span_begin;
          // x covers span_begin+1 .. span_finish
          dx  = SUM_W'(item_i.span_begin) * SUM_W'(len)
              + (SUM_W'(len) * (SUM_W'(len) + SUM_W'(1))) / SUM_W'(2);
          dy  = SUM_W'(len) * SUM_W'(item_i.row);
          accumulate_overlap(item_i.first_slot, len, dx, dy, item_i.second_polygon);
          accumulate_overlap(item_i.second_slot, len, dx, dy, item_i.first_polygon);
        end
      end
      OP_FRAME_END: queue_centroids();
      default: ;
    endcase
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_result();
    centroid_t want;
    if (expected_centroids.size() == 0) begin
      $error("unexpected result transfer for slot %0d", result_i.slot_index);
      mismatches++;
      return;
    end
    want = expected_centroids.pop_front();
    compare_field("slot_index", 32'(want.slot), 32'(result_i.slot_index));
    compare_field("pixel_count", 32'(want.count), 32'(result_i.pixel_count));
    compare_field("mean_x", 32'(want.mx), 32'(result_i.mean_x));
    compare_field("mean_y", 32'(want.my), 32'(result_i.mean_y));
    compare_field("partner_polygon", 32'(want.partner), 32'(result_i.partner_polygon));
    compare_field("last_slot", 32'(want.last), 32'(result_i.last_slot));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_slots();
      expected_centroids.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // results in flight always predate an item accepted on the same edge
      if (result_i.valid && result_i.ready) check_result();
      if (item_i.valid && item_i.ready) apply_item();
      pending_o        <= expected_centroids.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> dv/tb_span_collision_centroid_core.sv
// Testbench top: clock, reset, span item stimulus, result backpressure and the verdict.
module tb_span_collision_centroid_core;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned COORD_MAX    = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [SLOT_W-1:0]     first_slot;
    logic [SLOT_W-1:0]     second_slot;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] span_begin;
    logic [COORD_BITS-1:0] span_finish;
    logic [POLY_W-1:0]     first_polygon;
    logic [POLY_W-1:0]     second_polygon;
  } span_item_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned hold_left;
  bit          calm;

  scc_in_if  item_if();
  scc_out_if result_if();

  span_collision_centroid_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  scc_centroid_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item_if),
    .result_i         (result_if),
    .pending_o        (pending),
    .mismatch_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic span_item_t make_span(int unsigned a, int unsigned b, int unsigned y,
                                           int unsigned beg, int unsigned fin,
                                           int unsigned pa, int unsigned pb);
    span_item_t it;
    it.opcode         = OP_SPAN;
    it.first_slot     = SLOT_W'(a);
    it.second_slot    = SLOT_W'(b);
    it.row            = COORD_BITS'(y);
    it.span_begin     = COORD_BITS'(beg);
    it.span_finish    = COORD_BITS'(fin);
    it.first_polygon  = POLY_W'(pa);
    it.second_polygon = POLY_W'(pb);
    return it;
  endfunction

  // non-span items carry random junk in the unused fields
  function automatic span_item_t make_marker(logic [OPCODE_W-1:0] op);
    span_item_t it;
    it = make_span($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.opcode = op;
    return it;
  endfunction

  function automatic span_item_t random_span();
    span_item_t  it;
    int unsigned beg;
    int unsigned len;
    int unsigned a;
    beg = $urandom_range(0, COORD_MAX);
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = $urandom_range(0, COORD_MAX);
      default: len = $urandom_range(1, 40);
    endcase
    a  = $urandom_range(0, SLOTS - 1);
    it = make_span(a, ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, SLOTS - 1),
                   $urandom_range(0, COORD_MAX), beg,
                   (beg + len > COORD_MAX) ? COORD_MAX : beg + len,
                   ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535),
                   ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 65535));
    return it;
  endfunction

  function automatic span_item_t reversed_span();
    span_item_t it;
    it = random_span();
    it.span_begin  = COORD_BITS'($urandom_range(1, COORD_MAX));
    it.span_finish = COORD_BITS'($urandom_range(0, it.span_begin - 1));
    return it;
  endfunction

  task automatic send_item(input span_item_t it);
    int unsigned gap;
    item_if.valid          <= 1'b1;
    item_if.opcode         <= it.opcode;
    item_if.first_slot     <= it.first_slot;
    item_if.second_slot    <= it.second_slot;
    item_if.row            <= it.row;
    item_if.span_begin     <= it.span_begin;
    item_if.span_finish    <= it.span_finish;
    item_if.first_polygon  <= it.first_polygon;
    item_if.second_polygon <= it.second_polygon;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) @(posedge clk_i);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result backpressure
  initial begin
    result_if.ready <= 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        hold_left = pick_gap();
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned spans;
    calm = 1'b0;
    rst_ni                 <= 1'b0;
    item_if.valid          <= 1'b0;
    item_if.opcode         <= OP_FRAME_START;
    item_if.first_slot     <= '0;
    item_if.second_slot    <= '0;
    item_if.row            <= '0;
    item_if.span_begin     <= '0;
    item_if.span_finish    <= '0;
    item_if.first_polygon  <= '0;
    item_if.second_polygon <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, coordinate extremes, empty/reversed/self spans, unused opcode
    send_item(make_marker(OP_FRAME_END));
    send_item(make_span(0, SLOTS - 1, COORD_MAX, 0, COORD_MAX, 16'hffff, 16'h0000));
    send_item(make_span(1, 2, 0, COORD_MAX - 1, COORD_MAX, 16'h0000, 16'hffff));
    send_item(make_span(3, 4, 1000, 1000, 1000, 16'h1234, 16'habcd));
    send_item(make_span(5, 6, 77, COORD_MAX, 0, 16'h5a5a, 16'ha5a5));
    send_item(make_span(7, 7, 5, 10, 20, 16'h5555, 16'haaaa));
    send_item(make_span(SLOTS - 1, 0, 2047, 0, 1, 16'h8001, 16'h7ffe));
    send_item(make_marker(OP_UNUSED));
    send_item(make_marker(OP_FRAME_END));
    send_item(make_marker(OP_FRAME_END));
    send_item(make_marker(OP_FRAME_START));
    send_item(make_marker(OP_FRAME_END));

    // random frames: mostly start, spans, end; some noise between
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item(make_marker(OP_FRAME_START));
        sent++;
      end
      spans = $urandom_range(1, 16);
      repeat (spans) begin
        case ($urandom_range(0, 19))
          0:       send_item(make_marker(OP_UNUSED));
          1:       send_item(reversed_span());
          default: begin
            send_item(random_span());
            sent++;
          end
        endcase
      end
      send_item(make_marker(OP_FRAME_END));
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        send_item(make_marker(OP_FRAME_END));
        sent++;
      end
      calm = ($urandom_range(0, 4) == 0);
    end
    calm = 1'b0;
    item_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/scc_pkg.sv
hdl/scc_if.sv
hdl/scc_div.sv
hdl/span_collision_centroid_core.sv
dv/scc_centroid_checker.sv
dv/tb_span_collision_centroid_core.sv
